// File: hdl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and codes for the cascaded range remap block: item kinds,
// status codes, sequencer states and the layout of one stored range.
// ----------------------------------------------------------------------------
package crr_pkg;

	localparam int unsigned WORD_W = 32;

	typedef enum logic [1:0] {
		KIND_OPEN  = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_XLATE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_RANGE_FULL = 2'd1,
		ST_STAGE_FULL = 2'd2,
		ST_NO_STAGE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic              first;
		logic [WORD_W-1:0] tgt;
		logic [WORD_W-1:0] src;
		logic [WORD_W-1:0] len;
	} range_entry_t;

endpackage

// File: hdl/crr_range_mem.sv
// ----------------------------------------------------------------------------
// crr_range_mem
// Range store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crr_range_mem
	import crr_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic         clk,
	input  logic         wr_en,
	input  logic [AW-1:0] wr_addr,
	input  range_entry_t wr_data,
	input  logic [AW-1:0] rd_addr,
	output range_entry_t rd_data
);

	range_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: hdl/cascaded_range_remap.sv
// ----------------------------------------------------------------------------
// cascaded_range_remap
// Translates values through an ordered chain of range stages.
// Open, add and reserved items pass from S_IDLE through S_EMIT to the output
// register; a translation steps through S_SCAN once per stored range (up to
// MAX_RANGES), then S_FINISH and S_EMIT, or goes to S_EMIT when none is stored.
// Throughput: one item at a time; a translation scans one stored range per
// cycle through the single read port of the range store and one shared
// subtract/compare/add unit.
// Reset clears stage and range counts and sets the running minimum to all ones;
// the range store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module cascaded_range_remap
	import crr_pkg::*;
#(
	parameter int unsigned MAX_STAGES = 16,
	parameter int unsigned MAX_RANGES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [WORD_W-1:0] target_start,
	input  logic [WORD_W-1:0] source_start,
	input  logic [WORD_W-1:0] range_length,
	input  logic [WORD_W-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] location,
	output logic [WORD_W-1:0] lowest_location,
	output logic [1:0]        status
);

	localparam int unsigned IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_RANGES + 1);
	localparam int unsigned SCNT_W = $clog2(MAX_STAGES + 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  range_count_q;
	logic [SCNT_W-1:0] stage_count_q;
	logic              new_stage_q;
	logic [WORD_W-1:0] lowest_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_loc_q;
	status_t           out_status_q;
	logic              vld_s1;

	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] v_cur_q;
	logic [WORD_W-1:0] v_next_q;
	status_t           res_status_q;
	logic              xlate_q;

	logic              in_acc;
	logic              out_free;
	logic              stage_full;
	logic              range_full;
	logic              no_stage;
	logic              wr_en;
	range_entry_t      wr_data;
	range_entry_t      rd_s1;
	logic              last_idx;
	logic [WORD_W-1:0] v_base;
	logic [WORD_W-1:0] off;
	logic              hit;
	status_t           acc_status;

	assign stage_full = (stage_count_q == SCNT_W'(MAX_STAGES));
	assign range_full = (range_count_q == CNT_W'(MAX_RANGES));
	assign no_stage   = (stage_count_q == '0);
	assign last_idx   = (CNT_W'(idx_q) == range_count_q - CNT_W'(1));
	assign out_free   = !out_valid_q || !out_stall;

	assign wr_data.first = new_stage_q;
	assign wr_data.tgt   = target_start;
	assign wr_data.src   = source_start;
	assign wr_data.len   = range_length;

	crr_range_mem #(
		.DEPTH (MAX_RANGES),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (range_count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (idx_q),
		.rd_data (rd_s1)
	);

	assign v_base = rd_s1.first ? v_next_q : v_cur_q;
	assign off    = v_base - rd_s1.src;
	assign hit    = (off < rd_s1.len);

	always_comb begin
		state_d    = state_q;
		in_stall   = (state_q != S_IDLE);
		in_acc     = 1'b0;
		wr_en      = 1'b0;
		acc_status = ST_OK;
		unique case (kind)
			KIND_OPEN: begin
				if (stage_full) acc_status = ST_STAGE_FULL;
			end
			KIND_ADD: begin
				if (no_stage)        acc_status = ST_NO_STAGE;
				else if (range_full) acc_status = ST_RANGE_FULL;
			end
			default: acc_status = ST_OK;
		endcase
		unique case (state_q)
			S_IDLE: begin
				in_acc = in_valid;
				if (in_valid) begin
					if (kind == KIND_ADD && !no_stage && !range_full) wr_en = 1'b1;
					if (kind == KIND_XLATE && range_count_q != '0) state_d = S_SCAN;
					else                                           state_d = S_EMIT;
				end
			end
			S_SCAN: begin
				if (last_idx) state_d = S_FINISH;
			end
			S_FINISH: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			range_count_q <= '0;
			stage_count_q <= '0;
			new_stage_q   <= 1'b0;
			lowest_q      <= '1;
			out_valid_q   <= 1'b0;
			vld_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == S_SCAN);
			if (in_acc && kind == KIND_OPEN && !stage_full) begin
				stage_count_q <= stage_count_q + SCNT_W'(1);
				new_stage_q   <= 1'b1;
			end
			if (wr_en) begin
				range_count_q <= range_count_q + CNT_W'(1);
				new_stage_q   <= 1'b0;
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				if (xlate_q && v_next_q < lowest_q) lowest_q <= v_next_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q        <= '0;
			v_cur_q      <= value;
			v_next_q     <= (kind == KIND_XLATE) ? value : '0;
			xlate_q      <= (kind == KIND_XLATE);
			res_status_q <= acc_status;
		end else begin
			if (state_q == S_SCAN && !last_idx) idx_q <= idx_q + IDX_W'(1);
			if (vld_s1) begin
				v_cur_q <= v_base;
				if (hit)              v_next_q <= rd_s1.tgt + off;
				else if (rd_s1.first) v_next_q <= v_base;
			end
		end
		if (state_q == S_EMIT && out_free) begin
			out_loc_q    <= v_next_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign location        = out_loc_q;
	assign lowest_location = lowest_q;
	assign status          = out_status_q;

	a_lowest_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> lowest_q <= $past(lowest_q))
		else $error("running minimum increased");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		range_count_q <= CNT_W'(MAX_RANGES) && stage_count_q <= SCNT_W'(MAX_STAGES))
		else $error("table count beyond capacity");

	a_scan_step_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN || state_q == S_FINISH))
		else $error("range step outside scan");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !wr_en &&
			($past(state_q) == S_IDLE || $stable(range_count_q)))
		else $error("range store written during scan");

endmodule
